[design/mbe_pkg.sv]
// Shared types, constants and helpers for the escape-time block.
package mbe_pkg;

  localparam int DATA_W     = 32;  // Q4.28 word
  localparam int STEP_W     = 31;
  localparam int LIMIT_W    = 16;
  localparam int PROD_W     = 64;  // full product of two data words
  localparam int WIDE_W     = 66;  // headroom for sums before saturation
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLIDE_RE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLIDE_IM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT     = 3'd5;

  localparam logic signed [DATA_W-1:0] ORIGIN_RE_RST = 32'shDE666666;  // -2.1
  localparam logic signed [DATA_W-1:0] ORIGIN_IM_RST = 32'shECCCCCCD;  // -1.2
  localparam logic [STEP_W-1:0]        STEP_RST      = 31'd1342177;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST     = 16'd50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_HOLD
  } mbe_state_t;

  typedef struct packed {
    logic start;     // map pixel, clear z and count
    logic mul;       // capture the three products
    logic step;      // write back z, bump count
    logic load_out;  // copy count to output register
  } mbe_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } mbe_sts_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
    logic top_same;
    top_same = (&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]);
    if (top_same) begin
      sat_word = v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_word = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_word = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

[design/mbe_ctrl.sv]
// Sequencer for the escape-time iteration: mapping, multiply, update, hand-off.
module mbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output mbe_pkg::mbe_cmd_t cmd,
  input  mbe_pkg::mbe_sts_t sts
);
  import mbe_pkg::*;

  mbe_state_t state, state_next;
  logic       out_free;
  logic       finish;

  assign out_free = !out_valid || !out_stall;
  assign finish   = sts.escaped || sts.at_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_UPD;
      ST_UPD: begin
        if (!finish) begin
          state_next = ST_MUL;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_UPD: begin
        cmd.step     = !finish;
        cmd.load_out = finish && out_free;
      end
      ST_HOLD: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[design/mbe_datapath.sv]
// Mapping, z^2 + c arithmetic, escape test and iteration counter.
module mbe_datapath #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mbe_pkg::mbe_cmd_t                    cmd,
  output mbe_pkg::mbe_sts_t                    sts,
  input  logic [PIXEL_BITS-1:0]                pixel_col,
  input  logic [PIXEL_BITS-1:0]                pixel_row,
  input  logic signed [mbe_pkg::DATA_W-1:0]    origin_re,
  input  logic signed [mbe_pkg::DATA_W-1:0]    origin_im,
  input  logic signed [mbe_pkg::DATA_W-1:0]    slide_re,
  input  logic signed [mbe_pkg::DATA_W-1:0]    slide_im,
  input  logic [mbe_pkg::STEP_W-1:0]           pixel_step,
  input  logic [mbe_pkg::LIMIT_W-1:0]          iteration_limit,
  output logic [COUNT_BITS-1:0]                escape_count
);
  import mbe_pkg::*;

  localparam int MAP_W     = PIXEL_BITS + STEP_W;
  localparam int THR_SHIFT = 2 * FRAC_BITS + 2;  // |z|^2 >= 4.0 in product scale

  logic signed [DATA_W-1:0] point_re, point_im;
  logic signed [DATA_W-1:0] z_re, z_im;
  logic signed [PROD_W-1:0] sq_re, sq_im, cr;
  logic [LIMIT_W-1:0]       cnt;

  logic [MAP_W-1:0]         map_prod_re, map_prod_im;
  logic signed [WIDE_W-1:0] map_re, map_im;
  logic signed [WIDE_W-1:0] diff, cr_w, re_sum, im_sum;
  logic [PROD_W-1:0]        mag;

  // pixel to plane
  assign map_prod_re = MAP_W'(pixel_col) * MAP_W'(pixel_step);
  assign map_prod_im = MAP_W'(pixel_row) * MAP_W'(pixel_step);
  assign map_re = WIDE_W'(map_prod_re) + WIDE_W'(slide_re) + WIDE_W'(origin_re);
  assign map_im = WIDE_W'(map_prod_im) + WIDE_W'(slide_im) + WIDE_W'(origin_im);

  // update from registered products, floor shifts
  assign diff   = WIDE_W'(sq_re) - WIDE_W'(sq_im);
  assign cr_w   = WIDE_W'(cr);
  assign re_sum = (diff >>> FRAC_BITS) + WIDE_W'(point_re);
  assign im_sum = (cr_w >>> (FRAC_BITS - 1)) + WIDE_W'(point_im);

  // squares are non-negative, so the raw sum fits unsigned
  assign mag = PROD_W'(sq_re) + PROD_W'(sq_im);

  generate
    if (THR_SHIFT < PROD_W) begin : g_thr
      assign sts.escaped = |mag[PROD_W-1:THR_SHIFT];
    end else begin : g_no_thr
      assign sts.escaped = 1'b0;
    end
  endgenerate

  assign sts.at_limit = (cnt >= iteration_limit);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      point_re <= sat_word(map_re);
      point_im <= sat_word(map_im);
      z_re     <= '0;
      z_im     <= '0;
    end else if (cmd.step) begin
      z_re <= sat_word(re_sum);
      z_im <= sat_word(im_sum);
    end
    if (cmd.mul) begin
      sq_re <= z_re * z_re;
      sq_im <= z_im * z_im;
      cr    <= z_im * z_re;
    end
    if (cmd.load_out) begin
      escape_count <= COUNT_BITS'(cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + LIMIT_W'(1);
    end
  end

endmodule

[design/mandelbrot_escape_time.sv]
// Top level: APB register file, sequencer and datapath of the escape-time counter.
//
//   channel  direction  handshake             payload
//   pixel    in         in_valid / in_stall   pixel_col, pixel_row
//   count    out        out_valid / out_stall escape_count
//   config   in         APB (psel, penable)   pwdata -> six registers
//
// From acceptance a pixel is mapped, then makes n + 1 passes through the
// shared three-multiplier stage (a multiply state, then an update/test state),
// n being the iterations performed, the last pass only testing; its count then
// moves to the output register, after a wait in the hold state if that is stalled.
// One pixel is in flight at a time; the next is taken as soon as the count has
// moved to the output register, even while that transaction is still stalled.
// Reset (synchronous) empties the output and restores register defaults.
module mandelbrot_escape_time #(
  parameter int PIXEL_BITS = 12,
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // pixel transactions
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PIXEL_BITS-1:0]              pixel_col,
  input  logic [PIXEL_BITS-1:0]              pixel_row,
  // count transactions
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [COUNT_BITS-1:0]              escape_count,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbe_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::DATA_W-1:0]         pwdata,
  output logic [mbe_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import mbe_pkg::*;

  logic signed [DATA_W-1:0] origin_re, origin_im, slide_re, slide_im;
  logic [STEP_W-1:0]        pixel_step;
  logic [LIMIT_W-1:0]       iteration_limit;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     reg_wr;
  mbe_cmd_t                 cmd;
  mbe_sts_t                 sts;

  // ---- register file: word addresses, writes in the access phase ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re       <= ORIGIN_RE_RST;
      origin_im       <= ORIGIN_IM_RST;
      slide_re        <= '0;
      slide_im        <= '0;
      pixel_step      <= STEP_RST;
      iteration_limit <= LIMIT_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_ORIGIN_RE: origin_re       <= pwdata;
        REG_ORIGIN_IM: origin_im       <= pwdata;
        REG_SLIDE_RE:  slide_re        <= pwdata;
        REG_SLIDE_IM:  slide_im        <= pwdata;
        REG_STEP:      pixel_step      <= pwdata[STEP_W-1:0];
        REG_LIMIT:     iteration_limit <= pwdata[LIMIT_W-1:0];
        default: ;  // unmapped words ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_RE: prdata = origin_re;
      REG_ORIGIN_IM: prdata = origin_im;
      REG_SLIDE_RE:  prdata = slide_re;
      REG_SLIDE_IM:  prdata = slide_im;
      REG_STEP:      prdata = DATA_W'(pixel_step);
      REG_LIMIT:     prdata = DATA_W'(iteration_limit);
      default:       prdata = '0;
    endcase
  end

  // ---- sequencer ----
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // ---- arithmetic ----
  mbe_datapath #(
    .PIXEL_BITS (PIXEL_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_col       (pixel_col),
    .pixel_row       (pixel_row),
    .origin_re       (origin_re),
    .origin_im       (origin_im),
    .slide_re        (slide_re),
    .slide_im        (slide_im),
    .pixel_step      (pixel_step),
    .iteration_limit (iteration_limit),
    .escape_count    (escape_count)
  );

endmodule

[sim/mandelbrot_escape_time_tb.sv]
// Self-checking testbench for the Mandelbrot escape-time counter.
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  localparam int PIX_W = 12;
  localparam int CNT_W = 16;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // |z|^2 escape threshold, 4.0 with 2*28 fractional bits
  localparam logic [63:0] ESCAPE_MAG = 64'd4 << 56;
  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000;

  // random phase flavours: full view, deep zoom on the boundary,
  // random registers, and the unzoomed view with the slide folded into origin
  typedef enum int {
    VIEW_FULL,
    VIEW_ZOOM,
    VIEW_NOISE,
    VIEW_FOLDED
  } view_kind_t;

  typedef struct {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic [CNT_W-1:0] count;
  } pixel_count_t;

  // Keeps a private copy of the register file, works out the escape count of
  // every accepted pixel and checks returned counts in order.
  class escape_count_board;
    int           origin_re, origin_im, slide_re, slide_im;
    int unsigned  pixel_step, iter_limit;
    pixel_count_t counts_due[$];
    int           failures;

    function new();
      origin_re  = ORIGIN_RE_RST;
      origin_im  = ORIGIN_IM_RST;
      slide_re   = 0;
      slide_im   = 0;
      pixel_step = 32'(STEP_RST);
      iter_limit = 32'(LIMIT_RST);
      failures   = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_ORIGIN_RE: origin_re = data;
        REG_ORIGIN_IM: origin_im = data;
        REG_SLIDE_RE:  slide_re = data;
        REG_SLIDE_IM:  slide_im = data;
        REG_STEP:      pixel_step = 32'(data[STEP_W-1:0]);
        REG_LIMIT:     iter_limit = 32'(data[LIMIT_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    // z <- z^2 + c from z = 0, floor shifts and saturation as the datapath does
    function logic [CNT_W-1:0] iterate_point(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      longint          cr, ci, zr, zi, diff, cross_prod;
      logic [63:0]     mag;
      int unsigned     n;
      cr = clamp32(longint'(col) * longint'(pixel_step) + slide_re + origin_re);
      ci = clamp32(longint'(row) * longint'(pixel_step) + slide_im + origin_im);
      zr = 0;
      zi = 0;
      n  = 0;
      while (n < iter_limit) begin
        mag = zr * zr + zi * zi;
        if (mag >= ESCAPE_MAG) break;
        diff       = zr * zr - zi * zi;
        cross_prod = zi * zr;
        zr = clamp32((diff >>> 28) + cr);
        zi = clamp32((cross_prod >>> 27) + ci);
        n++;
      end
      return n[CNT_W-1:0];
    endfunction

    function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      pixel_count_t e;
      e.col   = col;
      e.row   = row;
      e.count = iterate_point(col, row);
      counts_due.push_back(e);
    endfunction

    function void check_count(logic [CNT_W-1:0] actual);
      pixel_count_t e;
      if (counts_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: escape_count %0d returned with no pixel outstanding", $time, actual);
        return;
      end
      e = counts_due.pop_front();
      if (e.count !== actual) begin
        failures++;
        if (failures <= 10)
          $display("%0t: pixel (%0d,%0d) escape_count expected %0d got %0d",
                   $time, e.col, e.row, e.count, actual);
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals - every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel_col = '0;
  logic [PIX_W-1:0]      pixel_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CNT_W-1:0]      escape_count;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  escape_count_board board;
  int                send_idle = 16;   // sender gap chance, percent
  int                recv_idle = 61;   // receiver stall chance, percent
  int unsigned       cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mandelbrot_escape_time uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .escape_count (escape_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Watchdog: a lost count or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Count side: sample the transaction on the pre-edge values, then pick the
  // stall for the next cycle at random.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_count(escape_count);
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access until pready; register lands on that edge
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // One pixel transaction, with random gaps in front; valid stays up
  // (payload frozen) until the block stops stalling.
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (in_stall);
    board.note_pixel(col, row);
  endtask

  // Stop sending and hold off until every count is back, then a short pause
  // so the sequencer is surely idle before the registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int fx(real v);
    return $rtoi(v * 268435456.0);
  endfunction

  function automatic int jitter(int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  // Load all six registers for one random phase.
  task automatic program_view(input view_kind_t kind);
    int unsigned step_val, lim;
    int          org_re, org_im, sld_re, sld_im, ctr_re, ctr_im;
    logic [31:0] step_word;
    sld_re = 0;
    sld_im = 0;
    case (kind)
      VIEW_FULL: begin
        // whole set across the 4096-pixel span, small pan
        step_val = $urandom_range(200000, 270000);
        org_re   = fx(-2.5);
        org_im   = fx(-1.6);
        sld_re   = jitter(1 << 25);
        sld_im   = jitter(1 << 25);
        lim      = $urandom_range(1, 64);
      end
      VIEW_ZOOM: begin
        // centre pixel 2048 on a point of the boundary, long counts likely
        case ($urandom_range(0, 3))
          0: begin ctr_re = fx(-0.75);   ctr_im = fx(0.1);    end
          1: begin ctr_re = fx(-0.1011); ctr_im = fx(0.9563); end
          2: begin ctr_re = fx(0.285);   ctr_im = fx(0.01);   end
          default: begin ctr_re = fx(-1.25); ctr_im = fx(0.02); end
        endcase
        step_val = $urandom_range(1, 1 << 14);
        org_re   = ctr_re - 2048 * int'(step_val);
        org_im   = ctr_im - 2048 * int'(step_val);
        lim      = $urandom_range(16, 256);
      end
      VIEW_NOISE: begin
        // arbitrary register contents; mostly instant escapes and saturation
        org_re   = $urandom;
        org_im   = $urandom;
        sld_re   = $urandom;
        sld_im   = $urandom;
        step_val = $urandom;
        lim      = $urandom_range(1, 128);
      end
      default: begin
        // unzoomed view: origin is loaded with the slide already taken off
        sld_re   = jitter(1 << 28);
        sld_im   = jitter(1 << 28);
        org_re   = fx(-2.1) - sld_re;
        org_im   = fx(-1.2) - sld_im;
        step_val = $urandom_range(100000, 300000);
        lim      = $urandom_range(1, 64);
      end
    endcase
    // unused upper bits get random junk; the block must ignore them
    step_word = {1'($urandom_range(0, 1)), step_val[30:0]};
    write_reg(REG_ORIGIN_RE, org_re);
    write_reg(REG_ORIGIN_IM, org_im);
    write_reg(REG_SLIDE_RE, sld_re);
    write_reg(REG_SLIDE_IM, sld_im);
    write_reg(REG_STEP, step_word);
    write_reg(REG_LIMIT, {16'($urandom), lim[15:0]});
  endtask

  // Corners of the pixel range, register extremes and the escape-test edges.
  task automatic directed_checks();
    // reset defaults: corners, two points inside the set, alternating bits
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(400, 240);
    send_pixel(250, 240);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    settle();
    // limit of one, junk in the upper half of the word
    write_reg(REG_LIMIT, 32'hFFFF_0001);
    send_pixel(400, 240);
    settle();
    // zero limit: count must come back as zero
    write_reg(REG_LIMIT, 32'h0001_0000);
    send_pixel(400, 240);
    settle();
    // zero step and full limit; slide moves c to -0.1, so the whole limit runs
    write_reg(REG_STEP, 32'h8000_0000);
    write_reg(REG_LIMIT, 32'h0000_FFFF);
    write_reg(REG_SLIDE_RE, fx(2.0));
    write_reg(REG_SLIDE_IM, 32'd322122547);
    send_pixel(4095, 4095);
    settle();
    // c = -2: |z|^2 hits exactly 4 and must count as escaped
    write_reg(REG_LIMIT, 32'd50);
    write_reg(REG_ORIGIN_RE, fx(-2.0));
    write_reg(REG_ORIGIN_IM, 32'd0);
    write_reg(REG_SLIDE_RE, 32'd0);
    write_reg(REG_SLIDE_IM, 32'd0);
    send_pixel(7, 9);
    settle();
    // cusp at c = 0.25, slowest convergence
    write_reg(REG_ORIGIN_RE, fx(0.25));
    send_pixel(1, 1);
    settle();
    // mapping saturates high on the real part; imaginary low at row 0, high at row 4095
    write_reg(REG_STEP, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_IM, 32'h8000_0000);
    write_reg(REG_SLIDE_RE, 32'h7FFF_FFFF);
    write_reg(REG_SLIDE_IM, 32'h8000_0000);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    settle();
    // and the other way round, smallest non-zero step
    write_reg(REG_ORIGIN_RE, 32'h8000_0000);
    write_reg(REG_ORIGIN_IM, 32'h7FFF_FFFF);
    write_reg(REG_SLIDE_RE, 32'h8000_0000);
    write_reg(REG_SLIDE_IM, 32'h7FFF_FFFF);
    write_reg(REG_STEP, 32'd1);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed transactions, then three idling regimes with one
  // phase of each view flavour; every phase ends with a full drain.
  // ---------------------------------------------------------------------------
  initial begin
    int mode, ph;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_checks();

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 16; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 16; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (ph = 0; ph < 4; ph++) begin
        program_view(view_kind_t'(ph));
        repeat (108) send_pixel(PIX_W'($urandom_range(0, 4095)),
                                PIX_W'($urandom_range(0, 4095)));
        settle();
      end
    end

    // long enough for a stray count at the largest random limit to show up
    repeat (600) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
